FILE: hw/rtl/ppa_pkg.sv
// Shared types and constants for the page pool allocator.
// Holds operation and status codes, sequencer states and the result record.
// No dependencies.
package ppa_pkg;

  localparam int OP_W          = 3;
  localparam int PAGE_W        = 6;
  localparam int CNT_W         = 7;
  localparam int TTL_W         = 31;
  localparam int STATUS_W      = 2;
  localparam int TOTAL_W       = 32;
  localparam int DEF_NUM_PAGES = 64;
  localparam int DEF_TIME_BITS = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_TOUCH = 3'd2,
    OP_SCAN  = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_BAD_PAGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SCAN_DONE
  } state_e;

  typedef struct packed {
    logic [PAGE_W-1:0]   page;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    reclaimed;
    logic [CNT_W-1:0]    free_count;
    logic [TOTAL_W-1:0]  alloc_total;
    logic [TOTAL_W-1:0]  free_total;
    logic                last;
  } res_t;

endpackage

FILE: hw/rtl/ppa_stack_mem.sv
// Free stack storage: one write and one registered read port.
// Entries never written read back as their own index (reset contents).
// Depends on ppa_pkg.
module ppa_stack_mem import ppa_pkg::*; #(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int PW        = $clog2(NUM_PAGES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [PW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [PW-1:0] waddr_i,
  input  logic [PW-1:0] wdata_i,
  output logic [PW-1:0] rdata_o
);

  logic [PW-1:0]        mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] written_q;
  logic [PW-1:0]        mem_rd_q;
  logic [PW-1:0]        addr_rd_q;
  logic                 vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      mem_rd_q  <= mem[raddr_i];
      addr_rd_q <= raddr_i;
      vld_rd_q  <= written_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (we_i) begin
      written_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = vld_rd_q ? mem_rd_q : addr_rd_q;

endmodule

FILE: hw/rtl/ppa_time_mem.sv
// Last-touch time storage: one write and one registered read port.
// Entries never written read back as zero.
// Depends on ppa_pkg.
module ppa_time_mem import ppa_pkg::*; #(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int TIME_BITS = DEF_TIME_BITS,
  parameter int PW        = $clog2(NUM_PAGES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 re_i,
  input  logic [PW-1:0]        raddr_i,
  input  logic                 we_i,
  input  logic [PW-1:0]        waddr_i,
  input  logic [TIME_BITS-1:0] wdata_i,
  output logic [TIME_BITS-1:0] rdata_o
);

  logic [TIME_BITS-1:0] mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] written_q;
  logic [TIME_BITS-1:0] mem_rd_q;
  logic                 vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      mem_rd_q <= mem[raddr_i];
      vld_rd_q <= written_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (we_i) begin
      written_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = vld_rd_q ? mem_rd_q : '0;

endmodule

FILE: hw/rtl/ppa_seq.sv
// Operation sequencer: decodes a command, walks the stack and time memories,
// keeps flags, clock and totals, and hands results to the output stage.
// Depends on ppa_pkg, ppa_stack_mem and ppa_time_mem.
module ppa_seq import ppa_pkg::*; #(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_fire_i,
  input  logic [OP_W-1:0]   cmd_op_i,
  input  logic [PAGE_W-1:0] cmd_page_i,
  input  logic [CNT_W-1:0]  cmd_count_i,
  input  logic [TTL_W-1:0]  cmd_ttl_i,
  output logic              idle_o,
  input  logic              res_free_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int LW = $clog2(NUM_PAGES + 1);
  localparam int CW = (TIME_BITS > TTL_W) ? TIME_BITS : TTL_W;

  state_e               state_q, state_d;
  logic [OP_W-1:0]      op_q;
  logic [PAGE_W-1:0]    id_q;
  logic [CNT_W-1:0]     n_q;
  logic [TTL_W-1:0]     ttl_q;
  logic [LW-1:0]        level_q, level_d;
  logic [NUM_PAGES-1:0] flags_q, flags_d;
  logic [TIME_BITS-1:0] clock_q, clock_d;
  logic [TOTAL_W-1:0]   alloc_tot_q, alloc_tot_d;
  logic [TOTAL_W-1:0]   free_tot_q, free_tot_d;
  logic [CNT_W-1:0]     remain_q, remain_d;
  logic [PW-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]     got_q, got_d;

  logic                 stk_re, stk_we;
  logic [PW-1:0]        stk_waddr, stk_wdata, stk_rdata;
  logic                 tm_re, tm_we;
  logic [PW-1:0]        tm_waddr;
  logic [TIME_BITS-1:0] tm_rdata;
  logic [LW-1:0]        lvl_m1;
  logic                 lvl_room, id_ok, last_idx, expired;
  logic [TIME_BITS-1:0] age;
  logic [PW-1:0]        id_pg;

  assign lvl_m1   = level_q - 1'b1;
  assign lvl_room = level_q < LW'(NUM_PAGES);
  assign id_ok    = CNT_W'(id_q) < CNT_W'(NUM_PAGES);
  assign id_pg    = id_q[PW-1:0];
  assign last_idx = idx_q == PW'(NUM_PAGES - 1);
  assign age      = clock_q - tm_rdata;
  assign expired  = CW'(age) > CW'(ttl_q);

  ppa_stack_mem #(.NUM_PAGES(NUM_PAGES), .PW(PW)) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (stk_re),
    .raddr_i (lvl_m1[PW-1:0]),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

  ppa_time_mem #(.NUM_PAGES(NUM_PAGES), .TIME_BITS(TIME_BITS), .PW(PW)) u_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (tm_re),
    .raddr_i (idx_q),
    .we_i    (tm_we),
    .waddr_i (tm_waddr),
    .wdata_i (clock_q),
    .rdata_o (tm_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_fire_i) begin
      op_q  <= cmd_op_i;
      id_q  <= cmd_page_i;
      n_q   <= cmd_count_i;
      ttl_q <= cmd_ttl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= LW'(NUM_PAGES);
      flags_q     <= '1;
      clock_q     <= '0;
      alloc_tot_q <= '0;
      free_tot_q  <= '0;
      remain_q    <= '0;
      idx_q       <= '0;
      got_q       <= '0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      flags_q     <= flags_d;
      clock_q     <= clock_d;
      alloc_tot_q <= alloc_tot_d;
      free_tot_q  <= free_tot_d;
      remain_q    <= remain_d;
      idx_q       <= idx_d;
      got_q       <= got_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    flags_d     = flags_q;
    clock_d     = clock_q;
    alloc_tot_d = alloc_tot_q;
    free_tot_d  = free_tot_q;
    remain_d    = remain_q;
    idx_d       = idx_q;
    got_d       = got_q;
    stk_re      = 1'b0;
    stk_we      = 1'b0;
    stk_waddr   = level_q[PW-1:0];
    stk_wdata   = id_pg;
    tm_re       = 1'b0;
    tm_we       = 1'b0;
    tm_waddr    = id_pg;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (cmd_fire_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_ALLOC: begin
            if (CNT_W'(level_q) < n_q) begin
              if (res_free_i) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_NO_SPACE;
                state_d      = S_IDLE;
              end
            end else if (n_q == '0) begin
              if (res_free_i) begin
                res_valid_o = 1'b1;
                state_d     = S_IDLE;
              end
            end else begin
              alloc_tot_d = alloc_tot_q + TOTAL_W'(n_q);
              remain_d    = n_q;
              state_d     = S_ALLOC_RD;
            end
          end
          OP_FREE: begin
            if (res_free_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
              if (!id_ok) begin
                res_o.status = ST_BAD_PAGE;
              end else if (flags_q[id_pg]) begin
                res_o.status = ST_ALREADY_FREE;
              end else begin
                flags_d[id_pg] = 1'b1;
                free_tot_d     = free_tot_q + 1'b1;
                if (lvl_room) begin
                  stk_we  = 1'b1;
                  level_d = level_q + 1'b1;
                end
              end
            end
          end
          OP_TOUCH: begin
            if (res_free_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
              if (!id_ok) begin
                res_o.status = ST_BAD_PAGE;
              end else begin
                tm_we = 1'b1;
              end
            end
          end
          OP_SCAN: begin
            idx_d   = '0;
            got_d   = '0;
            state_d = S_SCAN_RD;
          end
          OP_TICK: begin
            if (res_free_i) begin
              res_valid_o = 1'b1;
              clock_d     = clock_q + 1'b1;
              state_d     = S_IDLE;
            end
          end
          default: begin
            if (res_free_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
            end
          end
        endcase
      end
      S_ALLOC_RD: begin
        stk_re  = 1'b1;
        state_d = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        if (res_free_i) begin
          res_valid_o        = 1'b1;
          res_o.page         = PAGE_W'(stk_rdata);
          res_o.last         = remain_q == CNT_W'(1);
          level_d            = lvl_m1;
          flags_d[stk_rdata] = 1'b0;
          tm_we              = 1'b1;
          tm_waddr           = stk_rdata;
          remain_d           = remain_q - 1'b1;
          state_d            = (remain_q == CNT_W'(1)) ? S_IDLE : S_ALLOC_RD;
        end
      end
      S_SCAN_RD: begin
        if (flags_q[idx_q]) begin
          idx_d   = idx_q + 1'b1;
          state_d = last_idx ? S_SCAN_DONE : S_SCAN_RD;
        end else begin
          tm_re   = 1'b1;
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (expired) begin
          flags_d[idx_q] = 1'b1;
          free_tot_d     = free_tot_q + 1'b1;
          got_d          = got_q + 1'b1;
          stk_wdata      = idx_q;
          if (lvl_room) begin
            stk_we  = 1'b1;
            level_d = level_q + 1'b1;
          end
        end
        idx_d   = idx_q + 1'b1;
        state_d = last_idx ? S_SCAN_DONE : S_SCAN_RD;
      end
      S_SCAN_DONE: begin
        if (res_free_i) begin
          res_valid_o     = 1'b1;
          res_o.reclaimed = got_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.free_count  = CNT_W'(level_d);
    res_o.alloc_total = alloc_tot_d;
    res_o.free_total  = free_tot_d;
  end

endmodule

FILE: hw/rtl/page_pool_allocator_with_lease_reclaim_unit.sv
// Page pool allocator with lease reclaim: top level.
// Command channel (in_valid_i / in_stall_o) carries operation, page id, count
// and ttl; result channel (out_valid_o / out_stall_i) carries one transaction
// per result, with last_o high on the final result of a command.
// Operations: alloc pops count pages off a LIFO free stack (after reset the
// first page handed out is NUM_PAGES-1), free pushes a used page back, touch
// stamps a page with the millisecond clock, leak scan frees every used page
// older than ttl in ascending order, tick advances the clock.
// Timing: a command is taken only when the sequencer is idle. Free, touch,
// tick and invalid commands give their result from the execute state, and
// it is registered in the output register. Alloc reads the stack memory and
// then pops the page and writes its time stamp, for each page in turn. Leak
// scan tests the freed flag of each page in turn, plus one time memory read
// for each used page, then gives its result.
// Reset: all pages free, clock and totals zero; memory contents need no
// clearing pass, unwritten entries read as their reset value.
// Stall: the output register holds a result while out_stall_i is high; the
// sequencer waits with the next result, and a new command can still be
// taken once the last result of the previous one is in the output register.
// Depends on ppa_pkg and ppa_seq.
module page_pool_allocator_with_lease_reclaim_unit import ppa_pkg::*; #(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [PAGE_W-1:0]   page_id_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [TTL_W-1:0]    ttl_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PAGE_W-1:0]   page_number_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [CNT_W-1:0]    reclaimed_o,
  output logic [CNT_W-1:0]    free_count_o,
  output logic [TOTAL_W-1:0]  alloc_total_o,
  output logic [TOTAL_W-1:0]  free_total_o,
  output logic                last_o
);

  logic seq_idle;
  logic cmd_fire;
  logic res_free;
  logic res_valid;
  res_t res;
  res_t res_q;
  logic out_valid_q;

  assign in_stall_o = !seq_idle;
  assign cmd_fire   = in_valid_i && seq_idle;
  // output register can take a new result if empty or being drained now
  assign res_free   = !out_valid_q || !out_stall_i;

  ppa_seq #(.NUM_PAGES(NUM_PAGES), .TIME_BITS(TIME_BITS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_fire_i  (cmd_fire),
    .cmd_op_i    (operation_i),
    .cmd_page_i  (page_id_i),
    .cmd_count_i (count_i),
    .cmd_ttl_i   (ttl_i),
    .idle_o      (seq_idle),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign page_number_o = res_q.page;
  assign status_o      = res_q.status;
  assign reclaimed_o   = res_q.reclaimed;
  assign free_count_o  = res_q.free_count;
  assign alloc_total_o = res_q.alloc_total;
  assign free_total_o  = res_q.free_total;
  assign last_o        = res_q.last;

  // a result is only produced while a command is in progress
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("result produced while sequencer idle");

  // a result never overwrites one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_free)
    else $error("output register overwritten");

  // free stack never reports more pages than the pool holds
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_count_o <= CNT_W'(NUM_PAGES))
    else $error("free count out of range");

  // results with an error status or reclaimed pages must be final
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK || reclaimed_o != '0) |-> last_o)
    else $error("single result without last flag");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for page_pool_allocator_with_lease_reclaim_unit.
// A directed table runs first, then random command streams. A built-in pool
// predictor supplies the expected results. Depends on ppa_pkg and the RTL.
module tb import ppa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES = DEF_NUM_PAGES;
  localparam int DIR_N  = 25;
  localparam int RAND_N = 360;
  localparam int PHASE  = 40;

  // Operation codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam logic [TTL_W-1:0] TTL_MAX = 31'h7FFF_FFFF;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i;
  logic [PAGE_W-1:0]   page_id_i;
  logic [CNT_W-1:0]    count_i;
  logic [TTL_W-1:0]    ttl_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [PAGE_W-1:0]   page_number_o;
  logic [STATUS_W-1:0] status_o;
  logic [CNT_W-1:0]    reclaimed_o;
  logic [CNT_W-1:0]    free_count_o;
  logic [TOTAL_W-1:0]  alloc_total_o;
  logic [TOTAL_W-1:0]  free_total_o;
  logic                last_o;

  page_pool_allocator_with_lease_reclaim_unit u_top (.*);

  // Predicted pool state
  logic [PAGE_W-1:0]  free_stk [NPAGES];
  int unsigned        stk_level;
  bit                 is_free [NPAGES];
  logic [31:0]        stamp_ms [NPAGES];
  logic [31:0]        now_ms;
  logic [TOTAL_W-1:0] pages_handed;
  logic [TOTAL_W-1:0] pages_returned;

  res_t pending_results [$];

  bit          calm;          // no idling on either side in this phase
  int unsigned fail_cnt;
  int unsigned n_cmds;
  int unsigned n_results;
  int unsigned n_reclaimed;
  int unsigned n_granted;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  cnt;
    logic [TTL_W-1:0]  ttl;
    bit                typed;   // want holds the one result of this command
    res_t              want;
  } dir_row_t;

  // Page id NPAGES or above cannot be encoded with 64 pages, so no bad id row.
  dir_row_t dir_tab [DIR_N] = '{
    '{OP_ALLOC, 6'd0, 7'd0, 31'd0, 1'b1, '{6'd0, ST_OK, 7'd0, 7'd64, 32'd0, 32'd0, 1'b1}},
    '{OP_FREE, 6'd5, 7'd0, 31'd0, 1'b1,
      '{6'd0, ST_ALREADY_FREE, 7'd0, 7'd64, 32'd0, 32'd0, 1'b1}},
    '{OP_TOUCH, 6'd63, 7'd0, 31'd0, 1'b1,
      '{6'd0, ST_OK, 7'd0, 7'd64, 32'd0, 32'd0, 1'b1}},
    '{OP_ALLOC, 6'd0, 7'd127, 31'd0, 1'b1,
      '{6'd0, ST_NO_SPACE, 7'd0, 7'd64, 32'd0, 32'd0, 1'b1}},
    '{OP_ALLOC, 6'd0, 7'd65, 31'd0, 1'b1,
      '{6'd0, ST_NO_SPACE, 7'd0, 7'd64, 32'd0, 32'd0, 1'b1}},
    '{OP_ALLOC, 6'd0, 7'd1, 31'd0, 1'b1,
      '{6'd63, ST_OK, 7'd0, 7'd63, 32'd1, 32'd0, 1'b1}},
    '{OP_ALLOC, 6'd0, 7'd64, 31'd0, 1'b1,
      '{6'd0, ST_NO_SPACE, 7'd0, 7'd63, 32'd1, 32'd0, 1'b1}},
    '{OP_ALLOC, 6'd0, 7'd63, 31'd0, 1'b0, '0},
    '{OP_ALLOC, 6'd0, 7'd1, 31'd0, 1'b1,
      '{6'd0, ST_NO_SPACE, 7'd0, 7'd0, 32'd64, 32'd0, 1'b1}},
    '{OP_UNUSED_5, 6'd63, 7'd127, TTL_MAX, 1'b1,
      '{6'd0, ST_OK, 7'd0, 7'd0, 32'd64, 32'd0, 1'b1}},
    '{OP_UNUSED_6, 6'd63, 7'd127, TTL_MAX, 1'b1,
      '{6'd0, ST_OK, 7'd0, 7'd0, 32'd64, 32'd0, 1'b1}},
    '{OP_UNUSED_7, 6'd63, 7'd127, TTL_MAX, 1'b1,
      '{6'd0, ST_OK, 7'd0, 7'd0, 32'd64, 32'd0, 1'b1}},
    '{OP_TICK, 6'd0, 7'd0, 31'd0, 1'b1,
      '{6'd0, ST_OK, 7'd0, 7'd0, 32'd64, 32'd0, 1'b1}},
    '{OP_TOUCH, 6'd0, 7'd0, 31'd0, 1'b0, '0},
    '{OP_SCAN, 6'd0, 7'd0, TTL_MAX, 1'b1,
      '{6'd0, ST_OK, 7'd0, 7'd0, 32'd64, 32'd0, 1'b1}},
    '{OP_SCAN, 6'd0, 7'd0, 31'd0, 1'b0, '0},
    '{OP_FREE, 6'd0, 7'd0, 31'd0, 1'b0, '0},
    '{OP_FREE, 6'd0, 7'd0, 31'd0, 1'b0, '0},
    '{OP_FREE, 6'd63, 7'd0, 31'd0, 1'b0, '0},
    '{OP_ALLOC, 6'd0, 7'd64, 31'd0, 1'b0, '0},
    '{OP_TICK, 6'd0, 7'd0, 31'd0, 1'b0, '0},
    '{OP_TICK, 6'd0, 7'd0, 31'd0, 1'b0, '0},
    '{OP_SCAN, 6'd0, 7'd0, 31'd1, 1'b0, '0},
    '{OP_ALLOC, 6'd0, 7'd2, 31'd0, 1'b0, '0},
    '{OP_FREE, 6'd63, 7'd0, 31'd0, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_pool();
    for (int p = 0; p < NPAGES; p++) begin
      free_stk[p] = PAGE_W'(p);
      is_free[p]  = 1'b1;
      stamp_ms[p] = '0;
    end
    stk_level      = NPAGES;
    now_ms         = '0;
    pages_handed   = '0;
    pages_returned = '0;
  endfunction

  function automatic void push_result(logic [PAGE_W-1:0] pg, status_e st,
                                      logic [CNT_W-1:0] recl, logic fin);
    res_t r;
    r.page        = pg;
    r.status      = st;
    r.reclaimed   = recl;
    r.free_count  = CNT_W'(stk_level);
    r.alloc_total = pages_handed;
    r.free_total  = pages_returned;
    r.last        = fin;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void return_page(int p);
    is_free[p] = 1'b1;
    if (stk_level < NPAGES) begin
      free_stk[stk_level] = PAGE_W'(p);
      stk_level++;
    end
    pages_returned++;
  endfunction

  // Apply one accepted command to the predicted pool and queue its results
  function automatic void apply_pool_op(logic [OP_W-1:0] op, logic [PAGE_W-1:0] pid,
                                        logic [CNT_W-1:0] cnt, logic [TTL_W-1:0] ttl);
    logic [PAGE_W-1:0] pg;
    logic [31:0]       age;
    int unsigned       got;
    got = 0;
    case (op)
      OP_ALLOC: begin
        if (cnt > stk_level) begin
          push_result('0, ST_NO_SPACE, '0, 1'b1);
        end else if (cnt == 0) begin
          push_result('0, ST_OK, '0, 1'b1);
        end else begin
          pages_handed += TOTAL_W'(cnt);
          n_granted    += cnt;
          for (int i = 0; i < cnt; i++) begin
            stk_level--;
            pg           = free_stk[stk_level];
            is_free[pg]  = 1'b0;
            stamp_ms[pg] = now_ms;
            push_result(pg, ST_OK, '0, (i + 1 == cnt));
          end
        end
      end
      OP_FREE, OP_TOUCH: begin
        if (pid >= NPAGES) begin
          push_result('0, ST_BAD_PAGE, '0, 1'b1);
        end else if (op == OP_TOUCH) begin
          stamp_ms[pid] = now_ms;
          push_result('0, ST_OK, '0, 1'b1);
        end else if (is_free[pid]) begin
          push_result('0, ST_ALREADY_FREE, '0, 1'b1);
        end else begin
          return_page(pid);
          push_result('0, ST_OK, '0, 1'b1);
        end
      end
      OP_SCAN: begin
        // ascending walk; age wraps modulo 2^32
        for (int p = 0; p < NPAGES; p++) begin
          if (!is_free[p]) begin
            age = now_ms - stamp_ms[p];
            if (age > {1'b0, ttl}) begin
              return_page(p);
              got++;
            end
          end
        end
        n_reclaimed += got;
        push_result('0, ST_OK, CNT_W'(got), 1'b1);
      end
      OP_TICK: begin
        now_ms++;
        push_result('0, ST_OK, '0, 1'b1);
      end
      default: push_result('0, ST_OK, '0, 1'b1);
    endcase
  endfunction

  function automatic int unsigned idle_cycles();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // Drive one command transaction; returns at the falling edge after it was
  // taken, with valid still high so a back-to-back command needs no toggle.
  task automatic send_cmd(logic [OP_W-1:0] op, logic [PAGE_W-1:0] pid,
                          logic [CNT_W-1:0] cnt, logic [TTL_W-1:0] ttl,
                          bit typed, res_t want);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    page_id_i   <= pid;
    count_i     <= cnt;
    ttl_i       <= ttl;
    do @(posedge clk_i); while (in_stall_o);
    apply_pool_op(op, pid, cnt, ttl);
    if (typed) begin
      pending_results[pending_results.size() - 1] = want;
    end
    n_cmds++;
    @(negedge clk_i);
  endtask

  function automatic bit pick_used(output logic [PAGE_W-1:0] pg);
    int unsigned start;
    start = $urandom_range(0, NPAGES - 1);
    for (int k = 0; k < NPAGES; k++) begin
      if (!is_free[(start + k) % NPAGES]) begin
        pg = PAGE_W'((start + k) % NPAGES);
        return 1'b1;
      end
    end
    pg = PAGE_W'(start);
    return 1'b0;
  endfunction

  // Mostly well-formed traffic (allocs, frees and touches of live pages,
  // ticks, short-ttl scans); the rest is noise with fully random fields.
  task automatic random_cmd();
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] pid;
    logic [CNT_W-1:0]  cnt;
    logic [TTL_W-1:0]  ttl;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    pid  = PAGE_W'($urandom);
    cnt  = CNT_W'($urandom);
    ttl  = TTL_W'($urandom);
    if (roll < 24) begin
      op  = OP_ALLOC;
      cnt = (roll < 2) ? CNT_W'($urandom_range(7, 64)) : CNT_W'($urandom_range(1, 6));
    end else if (roll < 44) begin
      op = OP_FREE;
      void'(pick_used(pid));
    end else if (roll < 54) begin
      op = OP_TOUCH;
      void'(pick_used(pid));
    end else if (roll < 72) begin
      op = OP_TICK;
    end else if (roll < 82) begin
      op  = OP_SCAN;
      ttl = TTL_W'($urandom_range(0, 6));
    end else if (roll < 88) begin
      op = OP_ALLOC;
    end else if (roll < 93) begin
      op = (roll & 1) ? OP_FREE : OP_TOUCH;
    end else if (roll < 96) begin
      op = OP_SCAN;
    end else begin
      op = OP_UNUSED_5 + OP_W'($urandom_range(0, 2));
    end
    send_cmd(op, pid, cnt, ttl, 1'b0, '0);
  endtask

  // Stimulus and end of run
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = '0;
    page_id_i   = '0;
    count_i     = '0;
    ttl_i       = '0;
    calm        = 1'b0;
    fail_cnt    = 0;
    n_cmds      = 0;
    n_results   = 0;
    n_reclaimed = 0;
    n_granted   = 0;
    reset_pool();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_N; r++) begin
      send_cmd(dir_tab[r].op, dir_tab[r].page, dir_tab[r].cnt, dir_tab[r].ttl,
               dir_tab[r].typed, dir_tab[r].want);
    end

    for (int i = 0; i < RAND_N; i++) begin
      if (i % PHASE == 0) calm = ($urandom_range(0, 3) == 0);
      random_cmd();
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    // longest command is a full scan, well under this
    repeat (300) @(posedge clk_i);

    $display("Ran %0d commands, checked %0d results.", n_cmds, n_results);
    $display("Pages granted %0d, reclaimed by scans %0d.", n_granted, n_reclaimed);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stall before each result transaction
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = idle_cycles();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin
    res_t w;
    bit   ok;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: page_number %0d status %0d last %0d",
               page_number_o, status_o, last_o);
        fail_cnt++;
      end else begin
        w  = pending_results.pop_front();
        ok = 1'b1;
        ok &= field_ok("page_number", w.page, page_number_o);
        ok &= field_ok("status", w.status, status_o);
        ok &= field_ok("reclaimed", w.reclaimed, reclaimed_o);
        ok &= field_ok("free_count", w.free_count, free_count_o);
        ok &= field_ok("alloc_total", w.alloc_total, alloc_total_o);
        ok &= field_ok("free_total", w.free_total, free_total_o);
        ok &= field_ok("last", w.last, last_o);
        if (!ok) fail_cnt++;
      end
    end
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ppa_pkg.sv
hw/rtl/ppa_stack_mem.sv
hw/rtl/ppa_time_mem.sv
hw/rtl/ppa_seq.sv
hw/rtl/page_pool_allocator_with_lease_reclaim_unit.sv
sim/tb.sv
